/* rtl/agvg_pkg.sv */
// Arrow glyph vertex generator: shared types, widths and helpers.
// Used by the square root pipeline, the divider pipeline and the top level.
package agvg_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int LEN_W       = 33;
  localparam int RAD_W       = 2 * LEN_W;
  localparam int SQ_STEPS    = LEN_W;
  localparam int FBITS       = 29;
  localparam int Q_W         = FBITS + 1;
  localparam int NUM_W       = LEN_W + Q_W;
  localparam int DIV_STEPS   = Q_W;
  localparam int EOFF_W      = LEN_W + 1;
  localparam int WOFF_W      = 31;
  localparam int SUM_W       = 50;
  localparam int TEX_W       = 17;
  localparam int NUM_VERTS   = 7;
  localparam int BEAT_W      = 3;

  localparam logic [TEX_W-1:0] TEX_ZERO = TEX_W'(0);
  localparam logic [TEX_W-1:0] TEX_HALF = TEX_W'(32768);
  localparam logic [TEX_W-1:0] TEX_ONE  = TEX_W'(65536);

  localparam logic signed [SUM_W-1:0] SAT_MAX =
    SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  typedef enum logic [BEAT_W-1:0] {
    BEAT_START_L = 3'd0,
    BEAT_START_R = 3'd1,
    BEAT_SHAFT_R = 3'd2,
    BEAT_SHAFT_L = 3'd3,
    BEAT_TIP     = 3'd4,
    BEAT_HEAD_L  = 3'd5,
    BEAT_HEAD_R  = 3'd6
  } beat_e;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic [30:0]        head_length;
    logic [30:0]        head_width;
    logic [30:0]        shaft_width;
    logic [31:0]        rgba_color;
  } arrow_in_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [TEX_W-1:0]   tex_u;
    logic [TEX_W-1:0]   tex_v;
    logic [31:0]        vert_color;
    logic               degenerate;
    logic               last;
  } vertex_out_t;

  typedef struct packed {
    arrow_in_t            arrow;
    logic [2:0]           dneg;
    logic [2:0][LEN_W-1:0] dmag;
  } sq_side_t;

  typedef struct packed {
    arrow_in_t        arrow;
    logic [2:0]       dneg;
    logic [LEN_W-1:0] shaft;
    logic             deg;
  } div_side_t;

  function automatic logic signed [SUM_W-1:0] apply_sign(logic neg, logic [EOFF_W-1:0] mag);
    logic signed [SUM_W-1:0] m;
    m = $signed(SUM_W'(mag));
    return neg ? -m : m;
  endfunction

  function automatic logic [31:0] sat_coord(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    priority if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end else begin
      c = v;
    end
    return c[31:0];
  endfunction

endpackage

/* rtl/agvg_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Carries the arrow sideband alongside; depends on agvg_pkg.
module agvg_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [agvg_pkg::RAD_W-1:0] rad_i,
  input  agvg_pkg::sq_side_t        side_i,
  output logic                      valid_o,
  output logic [agvg_pkg::LEN_W-1:0] root_o,
  output agvg_pkg::sq_side_t        side_o
);
  import agvg_pkg::*;

  logic             v    [SQ_STEPS+1];
  logic [RAD_W-1:0] rad  [SQ_STEPS+1];
  logic [LEN_W+1:0] rem  [SQ_STEPS+1];
  logic [LEN_W-1:0] root [SQ_STEPS+1];
  sq_side_t         side [SQ_STEPS+1];

  assign v[0]    = valid_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_i;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [LEN_W+3:0] cur;
    logic [LEN_W+3:0] trial;
    logic [LEN_W+3:0] diff;
    logic             ge;

    assign cur   = {rem[k], rad[k][RAD_W-1 -: 2]};
    assign trial = {2'b00, root[k], 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (en_i) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad[k+1]  <= rad[k] << 2;
        rem[k+1]  <= ge ? diff[LEN_W+1:0] : cur[LEN_W+1:0];
        root[k+1] <= {root[k][LEN_W-2:0], ge};
        side[k+1] <= side[k];
      end
    end
  end

  assign valid_o = v[SQ_STEPS];
  assign root_o  = root[SQ_STEPS];
  assign side_o  = side[SQ_STEPS];

endmodule

/* rtl/agvg_div.sv */
// Four-lane pipelined restoring divider, one quotient bit per stage.
// All lanes share one divisor; carries the sideband. Depends on agvg_pkg.
module agvg_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [3:0][agvg_pkg::NUM_W-1:0] num_i,
  input  logic [agvg_pkg::LEN_W-1:0]      den_i,
  input  agvg_pkg::div_side_t            side_i,
  output logic                           valid_o,
  output logic [3:0][agvg_pkg::Q_W-1:0]   quo_o,
  output agvg_pkg::div_side_t            side_o
);
  import agvg_pkg::*;

  logic                  v    [DIV_STEPS+1];
  logic [LEN_W-1:0]      den  [DIV_STEPS+1];
  logic [3:0][LEN_W-1:0] rem  [DIV_STEPS+1];
  logic [3:0][Q_W-1:0]   nb   [DIV_STEPS+1];
  logic [3:0][Q_W-1:0]   quo  [DIV_STEPS+1];
  div_side_t             side [DIV_STEPS+1];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rem[0][l] = num_i[l][NUM_W-1:Q_W];
      nb[0][l]  = num_i[l][Q_W-1:0];
    end
  end

  assign v[0]    = valid_i;
  assign den[0]  = den_i;
  assign quo[0]  = '0;
  assign side[0] = side_i;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [3:0][LEN_W:0]   cur;
    logic [3:0][LEN_W:0]   diff;
    logic [3:0]            ge;
    logic [3:0][LEN_W-1:0] rem_d;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        cur[l]   = {rem[k][l], nb[k][l][Q_W-1]};
        diff[l]  = cur[l] - {1'b0, den[k]};
        ge[l]    = (cur[l] >= {1'b0, den[k]});
        rem_d[l] = ge[l] ? diff[l][LEN_W-1:0] : cur[l][LEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (en_i) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
        rem[k+1]  <= rem_d;
        for (int l = 0; l < 4; l++) begin
          nb[k+1][l]  <= nb[k][l] << 1;
          quo[k+1][l] <= {quo[k][l][Q_W-2:0], ge[l]};
        end
      end
    end
  end

  assign valid_o = v[DIV_STEPS];
  assign quo_o   = quo[DIV_STEPS];
  assign side_o  = side[DIV_STEPS];

endmodule

/* rtl/arrow_glyph_vertex_generator_core.sv */
// Arrow glyph vertex generator top level: front end, square root, dividers,
// offset math and the vertex beat serializer. Depends on agvg_pkg, agvg_sqrt, agvg_div.
// Throughput is set by the single-beat result port: seven vertices per arrow
// (one for a zero-length arrow, so those go one per cycle without out_stall_i);
// the 70-stage pipeline takes an arrow each cycle unless the serializer stalls it.
// Reset: asynchronous, clears all valid bits and the serializer; no clearing pass.
module arrow_glyph_vertex_generator_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  agvg_pkg::arrow_in_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output agvg_pkg::vertex_out_t out_data_o
);
  import agvg_pkg::*;

  logic adv;

  // front end: differences
  logic signed [2:0][LEN_W-1:0] d_c;
  logic [2:0]                   dneg_c;
  logic [2:0][LEN_W-1:0]        dmag_c;

  always_comb begin
    d_c[0] = LEN_W'(in_data_i.end_x) - LEN_W'(in_data_i.start_x);
    d_c[1] = LEN_W'(in_data_i.end_y) - LEN_W'(in_data_i.start_y);
    d_c[2] = LEN_W'(in_data_i.end_z) - LEN_W'(in_data_i.start_z);
    for (int i = 0; i < 3; i++) begin
      dneg_c[i] = d_c[i][LEN_W-1];
      dmag_c[i] = dneg_c[i] ? -d_c[i] : d_c[i];
    end
  end

  logic     s1_v_q, s2_v_q, s3_v_q;
  sq_side_t s1_side_q, s2_side_q, s3_side_q;
  logic [2:0][RAD_W-1:0] s2_sq_q;
  logic [RAD_W-1:0]      s3_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_side_q.arrow <= in_data_i;
      s1_side_q.dneg  <= dneg_c;
      s1_side_q.dmag  <= dmag_c;
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= RAD_W'(s1_side_q.dmag[i]) * RAD_W'(s1_side_q.dmag[i]);
      end
      s2_side_q <= s1_side_q;
      s3_rad_q  <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
      s3_side_q <= s2_side_q;
    end
  end

  // square root
  logic             sq_v;
  logic [LEN_W-1:0] sq_len;
  sq_side_t         sq_side;

  agvg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_v_q),
    .rad_i   (s3_rad_q),
    .side_i  (s3_side_q),
    .valid_o (sq_v),
    .root_o  (sq_len),
    .side_o  (sq_side)
  );

  // numerators for the dividers
  logic [LEN_W-1:0] head_c, shaft_c;
  assign head_c  = (LEN_W'(sq_side.arrow.head_length) < sq_len)
                   ? LEN_W'(sq_side.arrow.head_length) : sq_len;
  assign shaft_c = sq_len - head_c;

  logic                  s4_v_q;
  logic [3:0][NUM_W-1:0] s4_num_q;
  logic [LEN_W-1:0]      s4_den_q;
  div_side_t             s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (adv) begin
      s4_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s4_num_q[i] <= NUM_W'({sq_side.dmag[i], FBITS'(0)}) + NUM_W'(sq_len >> 1);
      end
      s4_num_q[3]     <= NUM_W'({shaft_c, 16'h0}) + NUM_W'(sq_len >> 1);
      s4_den_q        <= sq_len;
      s4_side_q.arrow <= sq_side.arrow;
      s4_side_q.dneg  <= sq_side.dneg;
      s4_side_q.shaft <= shaft_c;
      s4_side_q.deg   <= (sq_len == '0);
    end
  end

  logic                dv_v;
  logic [3:0][Q_W-1:0] dv_q;
  div_side_t           dv_side;

  agvg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_v_q),
    .num_i   (s4_num_q),
    .den_i   (s4_den_q),
    .side_i  (s4_side_q),
    .valid_o (dv_v),
    .quo_o   (dv_q),
    .side_o  (dv_side)
  );

  // products, rounding, vertex sums
  logic                      s5_v_q, s6_v_q, s7_v_q;
  div_side_t                 s5_side_q, s6_side_q;
  logic [2:0][NUM_W-1:0]     s5_e_q;
  logic [1:0][NUM_W-3:0]     s5_s_q, s5_h_q;
  logic [TEX_W-1:0]          s5_us_q, s6_us_q, s7_us_q;
  logic [2:0][EOFF_W-1:0]    s6_e_q;
  logic [1:0][WOFF_W-1:0]    s6_s_q, s6_h_q;
  logic [NUM_VERTS-1:0][2:0][31:0] s7_pos_q;
  logic [31:0]               s7_color_q;
  logic                      s7_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (adv) begin
      s5_v_q <= dv_v;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
    end
  end

  logic signed [2:0][SUM_W-1:0] st_c, en_c, e_c, rs_c, rh_c;

  always_comb begin
    st_c[0] = SUM_W'(s6_side_q.arrow.start_x);
    st_c[1] = SUM_W'(s6_side_q.arrow.start_y);
    st_c[2] = SUM_W'(s6_side_q.arrow.start_z);
    en_c[0] = SUM_W'(s6_side_q.arrow.end_x);
    en_c[1] = SUM_W'(s6_side_q.arrow.end_y);
    en_c[2] = SUM_W'(s6_side_q.arrow.end_z);
    for (int i = 0; i < 3; i++) begin
      e_c[i] = st_c[i] + apply_sign(s6_side_q.dneg[i], s6_e_q[i]);
    end
    rs_c[0] = apply_sign(!s6_side_q.dneg[1], EOFF_W'(s6_s_q[0]));
    rs_c[1] = apply_sign(s6_side_q.dneg[0], EOFF_W'(s6_s_q[1]));
    rs_c[2] = '0;
    rh_c[0] = apply_sign(!s6_side_q.dneg[1], EOFF_W'(s6_h_q[0]));
    rh_c[1] = apply_sign(s6_side_q.dneg[0], EOFF_W'(s6_h_q[1]));
    rh_c[2] = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_e_q[i] <= NUM_W'(dv_q[i]) * NUM_W'(dv_side.shaft);
      end
      s5_s_q[0] <= (NUM_W-2)'(dv_q[1]) * (NUM_W-2)'(dv_side.arrow.shaft_width);
      s5_s_q[1] <= (NUM_W-2)'(dv_q[0]) * (NUM_W-2)'(dv_side.arrow.shaft_width);
      s5_h_q[0] <= (NUM_W-2)'(dv_q[1]) * (NUM_W-2)'(dv_side.arrow.head_width);
      s5_h_q[1] <= (NUM_W-2)'(dv_q[0]) * (NUM_W-2)'(dv_side.arrow.head_width);
      s5_us_q   <= dv_q[3][TEX_W-1:0];
      s5_side_q <= dv_side;

      for (int i = 0; i < 3; i++) begin
        s6_e_q[i] <= EOFF_W'((s5_e_q[i] + (NUM_W'(1) << (FBITS - 1))) >> FBITS);
      end
      for (int i = 0; i < 2; i++) begin
        s6_s_q[i] <= WOFF_W'((s5_s_q[i] + ((NUM_W-2)'(1) << FBITS)) >> (FBITS + 1));
        s6_h_q[i] <= WOFF_W'((s5_h_q[i] + ((NUM_W-2)'(1) << FBITS)) >> (FBITS + 1));
      end
      s6_us_q   <= s5_us_q;
      s6_side_q <= s5_side_q;

      for (int i = 0; i < 3; i++) begin
        s7_pos_q[BEAT_START_L][i] <= sat_coord(st_c[i] - rs_c[i]);
        s7_pos_q[BEAT_START_R][i] <= sat_coord(st_c[i] + rs_c[i]);
        s7_pos_q[BEAT_SHAFT_R][i] <= sat_coord(e_c[i] + rs_c[i]);
        s7_pos_q[BEAT_SHAFT_L][i] <= sat_coord(e_c[i] - rs_c[i]);
        s7_pos_q[BEAT_TIP][i]     <= sat_coord(en_c[i]);
        s7_pos_q[BEAT_HEAD_L][i]  <= sat_coord(e_c[i] - rh_c[i]);
        s7_pos_q[BEAT_HEAD_R][i]  <= sat_coord(e_c[i] + rh_c[i]);
      end
      s7_us_q    <= s6_us_q;
      s7_color_q <= s6_side_q.arrow.rgba_color;
      s7_deg_q   <= s6_side_q.deg;
    end
  end

  // vertex beat serializer
  logic                            ser_v_q;
  beat_e                           beat_q;
  logic [NUM_VERTS-1:0][2:0][31:0] pos_q;
  logic [TEX_W-1:0]                us_q;
  logic [31:0]                     color_q;
  logic                            deg_q;
  logic                            take, last_beat, ser_free, load;

  assign take      = ser_v_q && !out_stall_i;
  assign last_beat = deg_q || (beat_q == BEAT_HEAD_R);
  assign ser_free  = !ser_v_q || (take && last_beat);
  assign adv       = !s7_v_q || ser_free;
  assign load      = s7_v_q && ser_free;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      beat_q  <= BEAT_START_L;
    end else if (load) begin
      ser_v_q <= 1'b1;
      beat_q  <= BEAT_START_L;
    end else if (take) begin
      if (last_beat) begin
        ser_v_q <= 1'b0;
      end else begin
        beat_q <= beat_e'(beat_q + BEAT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pos_q   <= s7_pos_q;
      us_q    <= s7_us_q;
      color_q <= s7_color_q;
      deg_q   <= s7_deg_q;
    end
  end

  logic [TEX_W-1:0] u_c, v_c;

  always_comb begin
    unique case (beat_q)
      BEAT_START_L: begin u_c = TEX_ZERO; v_c = TEX_ZERO; end
      BEAT_START_R: begin u_c = TEX_ZERO; v_c = TEX_ONE;  end
      BEAT_SHAFT_R: begin u_c = us_q;     v_c = TEX_ONE;  end
      BEAT_SHAFT_L: begin u_c = us_q;     v_c = TEX_ZERO; end
      BEAT_TIP:     begin u_c = TEX_ONE;  v_c = TEX_HALF; end
      BEAT_HEAD_L:  begin u_c = us_q;     v_c = TEX_ZERO; end
      BEAT_HEAD_R:  begin u_c = us_q;     v_c = TEX_ONE;  end
      default:      begin u_c = TEX_ZERO; v_c = TEX_ZERO; end
    endcase
  end

  always_comb begin
    out_data_o = '0;
    out_data_o.degenerate = deg_q;
    out_data_o.last       = last_beat;
    if (!deg_q) begin
      out_data_o.vert_x     = pos_q[beat_q][0];
      out_data_o.vert_y     = pos_q[beat_q][1];
      out_data_o.vert_z     = pos_q[beat_q][2];
      out_data_o.tex_u      = u_c;
      out_data_o.tex_v      = v_c;
      out_data_o.vert_color = color_q;
    end
  end

  assign out_valid_o = ser_v_q;

  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_v_q |-> (beat_q <= BEAT_HEAD_R))
    else $error("vertex beat index out of range");

  a_deg_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ser_v_q && deg_q) |-> (beat_q == BEAT_START_L))
    else $error("degenerate arrow past its single beat");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ser_v_q && out_stall_i) |=> (ser_v_q && $stable(beat_q)))
    else $error("serializer moved while the result port stalled");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s7_v_q && adv) |-> ser_free)
    else $error("pipeline advanced into a busy serializer");

endmodule
